// ----- rtl/core/pac_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package pac_pkg;

  localparam int MAX_CHARS = 1024;
  localparam int CELLS     = MAX_CHARS - 1;
  localparam int CHAR_W    = 8;
  localparam int CNT_W     = (MAX_CHARS > 2) ? $clog2(MAX_CHARS) : 1;
  localparam int SEEN_W    = $clog2(MAX_CHARS + 1);
  localparam int DRAIN_W   = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int COUNT_W   = 19;
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  typedef struct packed {
    logic step;
    logic clear;
    logic drain;
  } pac_ctl_t;

  typedef struct packed {
    logic [CHAR_W-1:0] hist;
    logic              valid;
    logic              flag;
    logic              flag_prev;
    logic [CNT_W-1:0]  cnt;
  } pac_link_t;

  typedef enum logic [2:0] {
    S_RUN   = 3'b001,
    S_DRAIN = 3'b010,
    S_OUT   = 3'b100
  } pac_state_t;

endpackage

`default_nettype wire

// ----- rtl/core/pac_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none

module pac_cell (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire pac_pkg::pac_ctl_t          ctl,
  input  wire logic [pac_pkg::CHAR_W-1:0] c,
  input  wire pac_pkg::pac_link_t         prev,
  output pac_pkg::pac_link_t              nxt
);

  logic [pac_pkg::CHAR_W-1:0] hist_r;
  logic                       valid_r;
  logic                       flag_r;
  logic [pac_pkg::CNT_W-1:0]  cnt_r;
  logic                       hit;

  // palindrome of this length ends at the new char
  assign hit = valid_r && (hist_r == c) && prev.flag_prev;

  always_ff @(posedge clk) begin
    if (ctl.step) begin
      hist_r <= prev.hist;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      flag_r  <= 1'b0;
      cnt_r   <= '0;
    end else begin
      if (ctl.clear) begin
        valid_r <= 1'b0;
        flag_r  <= 1'b0;
      end else if (ctl.step) begin
        valid_r <= prev.valid;
        flag_r  <= hit;
      end
      if (ctl.drain) begin
        cnt_r <= prev.cnt;
      end else if (ctl.step) begin
        cnt_r <= cnt_r + pac_pkg::CNT_W'(hit);
      end
    end
  end

  assign nxt.hist      = hist_r;
  assign nxt.valid     = valid_r;
  assign nxt.flag      = flag_r;
  assign nxt.flag_prev = prev.flag;
  assign nxt.cnt       = cnt_r;

endmodule

`default_nettype wire

// ----- rtl/core/palindromic_substring_counter_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Palindromic substring counter.
// Input channel (in_valid/in_ready): one character per transfer, in_last_char
// marks the final character of a string. Output channel (out_valid/out_ready):
// one result per string, the number of palindromic substrings of length two
// or more and a too_long flag for strings above MAX_CHARS characters.
// While input is not held off, characters stream at one per cycle: a row of
// MAX_CHARS-1 cells holds the history, compares every kept character with the
// new one in parallel and keeps a per-length hit count in each cell.
// After the last character the per-cell counts shift down the row into one
// accumulator; the result is valid on the cycle after that sweep ends.
// Input is held off during that sweep; a new string may start in the cycle
// the result transfers. Characters beyond MAX_CHARS are dropped.
// While the receiver stalls the result holds and no new character is taken.
// Synchronous reset (rst_n low) empties the history and counts; no result
// is pending afterwards.

module palindromic_substring_counter_unit (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [7:0]                  in_char_code,
  input  wire logic                        in_last_char,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [pac_pkg::COUNT_W-1:0]      out_palindrome_count,
  output logic                             out_too_long
);

  pac_pkg::pac_state_t               state_r, state_nxt;
  logic [pac_pkg::SEEN_W-1:0]        seen_r, seen_nxt;
  logic                              overflow_r, overflow_nxt;
  logic                              too_long_r, too_long_nxt;
  logic [pac_pkg::COUNT_W-1:0]       acc_r, acc_nxt;
  logic [pac_pkg::DRAIN_W-1:0]       drain_cnt_r, drain_cnt_nxt;
  logic [pac_pkg::COUNT_W:0]         sum;
  logic                              in_fire;
  logic                              last_fire;
  logic                              full;
  logic                              drain_done;
  pac_pkg::pac_ctl_t                 ctl;
  pac_pkg::pac_link_t                link [pac_pkg::CELLS+1];

  assign in_ready   = (state_r == pac_pkg::S_RUN) ||
                      ((state_r == pac_pkg::S_OUT) && out_ready);
  assign in_fire    = in_valid && in_ready;
  assign last_fire  = in_fire && in_last_char;
  assign full       = (seen_r == pac_pkg::SEEN_W'(pac_pkg::MAX_CHARS));
  assign drain_done = (drain_cnt_r == pac_pkg::DRAIN_W'(pac_pkg::CELLS - 1));

  assign ctl.step  = in_fire && !full;
  assign ctl.clear = last_fire;
  assign ctl.drain = (state_r == pac_pkg::S_DRAIN);

  // head of the row: new char, lengths zero and one always match
  assign link[0].hist      = in_char_code;
  assign link[0].valid     = 1'b1;
  assign link[0].flag      = 1'b1;
  assign link[0].flag_prev = 1'b1;
  assign link[0].cnt       = '0;

  for (genvar i = 0; i < pac_pkg::CELLS; i++) begin : g_cell
    pac_cell u_cell (
      .clk  (clk),
      .rst_n(rst_n),
      .ctl  (ctl),
      .c    (in_char_code),
      .prev (link[i]),
      .nxt  (link[i+1])
    );
  end

  assign sum = {1'b0, acc_r} +
               (pac_pkg::COUNT_W+1)'(link[pac_pkg::CELLS].cnt);

  always_comb begin
    state_nxt     = state_r;
    seen_nxt      = seen_r;
    overflow_nxt  = overflow_r;
    too_long_nxt  = too_long_r;
    acc_nxt       = acc_r;
    drain_cnt_nxt = drain_cnt_r;

    if (last_fire) begin
      seen_nxt     = '0;
      overflow_nxt = 1'b0;
      too_long_nxt = overflow_r || full;
    end else if (in_fire) begin
      if (full) begin
        overflow_nxt = 1'b1;
      end else begin
        seen_nxt = seen_r + 1'b1;
      end
    end

    case (state_r)
      pac_pkg::S_RUN: begin
        if (last_fire) begin
          state_nxt     = pac_pkg::S_DRAIN;
          acc_nxt       = '0;
          drain_cnt_nxt = '0;
        end
      end
      pac_pkg::S_DRAIN: begin
        acc_nxt       = sum[pac_pkg::COUNT_W] ? pac_pkg::COUNT_MAX
                                              : sum[pac_pkg::COUNT_W-1:0];
        drain_cnt_nxt = drain_cnt_r + 1'b1;
        if (drain_done) begin
          state_nxt = pac_pkg::S_OUT;
        end
      end
      pac_pkg::S_OUT: begin
        if (last_fire) begin
          state_nxt     = pac_pkg::S_DRAIN;
          acc_nxt       = '0;
          drain_cnt_nxt = '0;
        end else if (out_ready) begin
          state_nxt = pac_pkg::S_RUN;
        end
      end
      default: begin
        state_nxt = pac_pkg::S_RUN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= pac_pkg::S_RUN;
      seen_r     <= '0;
      overflow_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      seen_r     <= seen_nxt;
      overflow_r <= overflow_nxt;
    end
  end

  always_ff @(posedge clk) begin
    too_long_r  <= too_long_nxt;
    acc_r       <= acc_nxt;
    drain_cnt_r <= drain_cnt_nxt;
  end

  assign out_valid            = (state_r == pac_pkg::S_OUT);
  assign out_palindrome_count = acc_r;
  assign out_too_long         = too_long_r;

  a_no_input_in_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == pac_pkg::S_DRAIN) |-> !in_ready)
    else $error("input taken during count sweep");

  a_last_starts_drain: assert property (@(posedge clk) disable iff (!rst_n)
    last_fire |=> (state_r == pac_pkg::S_DRAIN) && (seen_r == '0))
    else $error("last transfer did not start count sweep");

  a_seen_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    seen_r <= pac_pkg::SEEN_W'(pac_pkg::MAX_CHARS))
    else $error("character count beyond history size");

  a_drain_ends_in_out: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == pac_pkg::S_DRAIN) && drain_done) |=> out_valid)
    else $error("result not presented after count sweep");

endmodule

`default_nettype wire

// ----- tb/palindromic_substring_counter_unit_tb.sv -----
`timescale 1ns / 1ps

module palindromic_substring_counter_unit_tb;

  typedef struct {
    logic [pac_pkg::COUNT_W-1:0] count;
    logic                        too_long;
  } pal_result_t;

  typedef logic [7:0] char_q_t[$];

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        in_valid = 1'b0;
  logic                        in_ready;
  logic [7:0]                  in_char_code = 8'h00;
  logic                        in_last_char = 1'b0;
  logic                        out_valid;
  logic                        out_ready = 1'b0;
  logic [pac_pkg::COUNT_W-1:0] out_palindrome_count;
  logic                        out_too_long;

  // predictor state
  logic [7:0]   pal_hist[pac_pkg::MAX_CHARS];
  bit           pal_ends[pac_pkg::MAX_CHARS + 1];
  int unsigned  pal_total;
  int unsigned  pal_kept;
  bit           pal_over;

  pal_result_t  expected_counts[$];
  pal_result_t  exp_res;
  int           fail_count = 0;
  int           stall_left = 0;
  bit           idle_on = 1'b1;
  int           chars_sent = 0;

  palindromic_substring_counter_unit u_top (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_char_code         (in_char_code),
    .in_last_char         (in_last_char),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_palindrome_count (out_palindrome_count),
    .out_too_long         (out_too_long)
  );

  always #5 clk = ~clk;

  initial begin
    #20_000_000;
    $display("palindromic_substring_counter_unit: mismatch");
    $finish;
  end

  function automatic void clear_palindromes();
    foreach (pal_hist[i]) pal_hist[i] = 8'h00;
    foreach (pal_ends[i]) pal_ends[i] = 1'b0;
    pal_total = 0;
    pal_kept  = 0;
    pal_over  = 1'b0;
  endfunction

  // flag for length n: char n-1 back matches and length n-2 ended one position earlier
  function automatic void absorb_char(input logic [7:0] c);
    int unsigned hits;
    int          len;
    bit          inner;
    hits = 0;
    if (pal_kept >= pac_pkg::MAX_CHARS) begin
      pal_over = 1'b1;
      return;
    end
    for (len = pal_kept + 1; len >= 2; len--) begin
      inner = (len <= 3) ? 1'b1 : pal_ends[len - 2];
      pal_ends[len] = inner && (pal_hist[pal_kept - (len - 1)] == c);
      if (pal_ends[len]) hits++;
    end
    pal_hist[pal_kept] = c;
    pal_kept++;
    if (hits > int'(pac_pkg::COUNT_MAX) - pal_total) pal_total = 32'(pac_pkg::COUNT_MAX);
    else pal_total += hits;
  endfunction

  task automatic send_char(input logic [7:0] c, input logic last);
    int gap;
    gap = idle_on ? $urandom_range(0, 6) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_char_code <= c;
    in_last_char <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    chars_sent++;
    absorb_char(c);
    if (last) begin
      expected_counts.push_back('{count: pal_total[pac_pkg::COUNT_W-1:0],
                                  too_long: pal_over});
      clear_palindromes();
    end
  endtask

  task automatic send_string(input char_q_t s);
    foreach (s[i]) send_char(s[i], i == s.size() - 1);
  endtask

  task automatic test_short_strings();
    send_string({8'h00});
    send_string({8'hff, 8'hff});
    send_string({8'h00, 8'hff, 8'h00});
    send_string({8'ha5, 8'h5a, 8'h5a, 8'ha5});
    send_string({8'h41, 8'h41, 8'h41, 8'h41, 8'h41});
    send_string({8'h01, 8'h02, 8'h03});
  endtask

  task automatic test_full_history();
    char_q_t s;
    idle_on = 1'b0;
    for (int i = 0; i < pac_pkg::MAX_CHARS; i++) s.push_back(8'h7a);
    send_string(s);
    idle_on = 1'b1;
  endtask

  task automatic test_too_long();
    char_q_t s;
    logic [7:0] a, b;
    a = 8'($urandom_range(0, 255));
    b = ~a;
    idle_on = 1'b0;
    for (int i = 0; i < pac_pkg::MAX_CHARS + 3; i++) s.push_back($urandom_range(0, 1) ? a : b);
    send_string(s);
    idle_on = 1'b1;
  endtask

  task automatic test_random_strings();
    char_q_t    s;
    char_q_t    half;
    logic [7:0] syms[3];
    int         n, pick, style;
    while (chars_sent < pac_pkg::MAX_CHARS * 2 + 350) begin
      s.delete();
      half.delete();
      idle_on = ($urandom_range(0, 3) != 0);
      pick = $urandom_range(0, 99);
      n = (pick < 70) ? $urandom_range(1, 12) :
          (pick < 95) ? $urandom_range(13, 60) : $urandom_range(61, 200);
      syms[0] = 8'($urandom_range(0, 255));
      syms[1] = syms[0] ^ (8'h01 << $urandom_range(0, 7));
      syms[2] = 8'($urandom_range(0, 255));
      style = $urandom_range(0, 3);
      case (style)
        0: begin
          for (int i = 0; i < n; i++) s.push_back(8'($urandom_range(0, 255)));
        end
        1: begin
          for (int i = 0; i < n; i++) s.push_back(syms[$urandom_range(0, 1)]);
        end
        2: begin
          for (int i = 0; i < n; i++) s.push_back(syms[$urandom_range(0, 2)]);
        end
        default: begin
          // mirrored string, whole string is a palindrome
          for (int i = 0; i < (n + 1) / 2; i++) half.push_back(syms[$urandom_range(0, 2)]);
          s = half;
          if (n % 2) void'(half.pop_back());
          for (int i = half.size() - 1; i >= 0; i--) s.push_back(half[i]);
        end
      endcase
      send_string(s);
    end
    idle_on = 1'b1;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      stall_left = $urandom_range(0, 6);
    end else if (out_valid && out_ready) begin
      if (expected_counts.size() == 0) begin
        $error("result transfer with no result expected: count %0d too_long %0b",
               out_palindrome_count, out_too_long);
        fail_count++;
      end else begin
        exp_res = expected_counts.pop_front();
        if (out_palindrome_count !== exp_res.count) begin
          $error("palindrome_count: expected %0d, actual %0d",
                 exp_res.count, out_palindrome_count);
          fail_count++;
        end
        if (out_too_long !== exp_res.too_long) begin
          $error("too_long: expected %0b, actual %0b", exp_res.too_long, out_too_long);
          fail_count++;
        end
      end
      stall_left = idle_on ? $urandom_range(0, 6) : 0;
    end else if (out_valid && stall_left > 0) begin
      stall_left--;
    end
    out_ready <= (stall_left == 0);
  end

  initial begin
    int waited;
    clear_palindromes();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    test_short_strings();
    test_full_history();
    test_too_long();
    test_random_strings();
    in_valid     <= 1'b0;
    in_last_char <= 1'b0;
    waited = 0;
    while (expected_counts.size() != 0 && waited < 100_000) begin
      @(posedge clk);
      waited++;
    end
    repeat (pac_pkg::MAX_CHARS + 16) @(posedge clk);
    if (fail_count == 0 && expected_counts.size() == 0) begin
      $display("palindromic_substring_counter_unit: match");
    end else begin
      $display("palindromic_substring_counter_unit: mismatch");
    end
    $finish;
  end

endmodule
